/* hdl/life_generation_engine_defines.svh */
// Assertion macros shared by the life generation engine RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef LIFE_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GENERATION_ENGINE_DEFINES_SVH

// Same-cycle implication
`define LGE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lge_pkg.sv */
// Package for the life generation engine: payload types, codes, state types
// and the B3/S23 cell rule. No dependencies.
`timescale 1ns / 1ps

package lge_pkg;

  // Field and counter widths fixed by the item format
  localparam int REG_W   = 7;
  localparam int INDEX_W = 12;
  localparam int CELLS_W = 2 * REG_W;

  localparam int DEFAULT_MAX_WIDTH  = 64;
  localparam int DEFAULT_MAX_HEIGHT = 64;
  localparam int DEFAULT_DEPTH      = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT;

  localparam logic [REG_W-1:0] BOARD_DIM_RESET = 7'd64;

  // Rule constants
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Configuration register indexes
  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] cell_index;
    logic               cell_value;
  } item_t;

  typedef struct packed {
    logic read_value;
    logic index_error;
  } result_t;

  typedef struct packed {
    logic             index;
    logic [REG_W-1:0] value;
  } cfg_write_t;

  // Command from the control FSM to the board core
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_ADVANCE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    logic    value;
  } cmd_t;

  // Effective board size, already clamped
  typedef struct packed {
    logic [REG_W-1:0]   width;
    logic [REG_W-1:0]   height;
    logic [CELLS_W-1:0] cells;
  } board_dims_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_GEN,
    CTL_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_SCAN,
    SW_DRAIN,
    SW_FLUSH
  } sweep_state_t;

  // Which row of the 3-high column a read fetches
  typedef enum logic [1:0] {
    PH_TOP,
    PH_MID,
    PH_BOT
  } phase_t;

  // B3/S23: nb holds the eight neighbours, alive the centre cell
  function automatic logic next_cell(input logic [7:0] nb, input logic alive);
    logic [3:0] live;
    live = '0;
    for (int i = 0; i < 8; i++) begin
      live = live + 4'(nb[i]);
    end
    return (live == BIRTH_COUNT) || (alive && (live == SURVIVE_COUNT));
  endfunction

endpackage

/* hdl/lge_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// Depends on nothing; payload types come from lge_pkg at instantiation.
`timescale 1ns / 1ps

interface lge_if #(parameter type payload_t = logic) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* hdl/life_generation_engine.sv */
// Life generation engine: B3/S23 on a bounded board, one item at a time.
// The pace of an advance is set by the single read port of the current board RAM,
// three reads per window column; copy-back to the board overlaps the scan.
// Reset: width and height 64, control cleared; board RAMs undefined until written.
`timescale 1ns / 1ps

`include "life_generation_engine_defines.svh"

module life_generation_engine #(
  parameter int MAX_WIDTH  = lge_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = lge_pkg::DEFAULT_MAX_HEIGHT
) (
  input logic  clk,
  input logic  rst,
  lge_if.sink  item_in,
  lge_if.source result_out,
  lge_if.sink  cfg
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = lge_pkg::CELLS_W;
  localparam int RW    = lge_pkg::REG_W;

  lge_pkg::ctl_state_t  state, state_next;
  lge_pkg::cmd_t        cmd;
  lge_pkg::board_dims_t dims;
  lge_pkg::result_t     out_data;

  logic [RW-1:0] board_width, board_height, eff_w, eff_h;
  logic          accept, idx_ok, load_out, core_rd, core_done;
  logic          pend_rd, pend_err, out_valid;

  // Clamp the size registers
  assign eff_w = (board_width == '0) ? RW'(1) :
                 (int'(board_width) > MAX_WIDTH) ? RW'(MAX_WIDTH) : board_width;
  assign eff_h = (board_height == '0) ? RW'(1) :
                 (int'(board_height) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : board_height;
  assign dims.width  = eff_w;
  assign dims.height = eff_h;
  assign dims.cells  = CW'(eff_w) * CW'(eff_h);

  assign accept = item_in.valid && item_in.ready;
  assign idx_ok = CW'(item_in.data.cell_index) < dims.cells;

  assign item_in.ready    = (state == lge_pkg::CTL_IDLE);
  assign cfg.ready        = 1'b1;
  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= lge_pkg::BOARD_DIM_RESET;
      board_height <= lge_pkg::BOARD_DIM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.index)
        lge_pkg::REG_BOARD_WIDTH:  board_width  <= cfg.data.value;
        lge_pkg::REG_BOARD_HEIGHT: board_height <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // Control state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lge_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and core command
  always_comb begin
    state_next = state;
    cmd.op     = lge_pkg::OP_NONE;
    cmd.value  = item_in.data.cell_value;
    load_out   = 1'b0;
    unique case (state)
      lge_pkg::CTL_IDLE: begin
        if (accept) begin
          unique case (item_in.data.kind)
            lge_pkg::KIND_WRITE: begin
              if (idx_ok) cmd.op = lge_pkg::OP_WRITE;
              state_next = lge_pkg::CTL_DONE;
            end
            lge_pkg::KIND_ADVANCE: begin
              cmd.op     = lge_pkg::OP_ADVANCE;
              state_next = lge_pkg::CTL_GEN;
            end
            lge_pkg::KIND_READ: begin
              if (idx_ok) begin
                cmd.op     = lge_pkg::OP_READ;
                state_next = lge_pkg::CTL_READ;
              end else begin
                state_next = lge_pkg::CTL_DONE;
              end
            end
            default: state_next = lge_pkg::CTL_DONE;
          endcase
        end
      end
      lge_pkg::CTL_READ: state_next = lge_pkg::CTL_DONE;
      lge_pkg::CTL_GEN: begin
        if (core_done) state_next = lge_pkg::CTL_DONE;
      end
      lge_pkg::CTL_DONE: begin
        if (!out_valid || result_out.ready) begin
          load_out   = 1'b1;
          state_next = lge_pkg::CTL_IDLE;
        end
      end
      default: state_next = lge_pkg::CTL_IDLE;
    endcase
  end

  // Pending result of the item at work
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_rd  <= 1'b0;
      pend_err <= ((item_in.data.kind == lge_pkg::KIND_WRITE) ||
                   (item_in.data.kind == lge_pkg::KIND_READ)) && !idx_ok;
    end else if (state == lge_pkg::CTL_READ) begin
      pend_rd <= core_rd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.read_value  <= pend_rd;
      out_data.index_error <= pend_err;
    end
  end

  lge_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .addr   (AW'(item_in.data.cell_index)),
    .dims   (dims),
    .rd_bit (core_rd),
    .done   (core_done)
  );

  `LGE_ASSERT_NOW(a_result_from_done, $rose(out_valid), $past(state == lge_pkg::CTL_DONE), "result shown outside done state")
  `LGE_ASSERT_NOW(a_core_done_in_gen, core_done, state == lge_pkg::CTL_GEN, "generation finished without an advance")
  `LGE_ASSERT_NEXT(a_advance_enters_gen, accept && (item_in.data.kind == lge_pkg::KIND_ADVANCE), state == lge_pkg::CTL_GEN, "advance did not start a generation")

endmodule

/* hdl/lge_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on lge_pkg for the default depth.
`timescale 1ns / 1ps

module lge_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = lge_pkg::DEFAULT_DEPTH,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lge_core.sv */
// Board store and generation sweep: current and next board RAMs, raster
// scan with a 3x3 window, in-flight copy-back. Uses lge_pkg, lge_ram.
`timescale 1ns / 1ps

`include "life_generation_engine_defines.svh"

module lge_core #(
  parameter int MAX_WIDTH  = lge_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = lge_pkg::DEFAULT_MAX_HEIGHT,
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  lge_pkg::cmd_t       cmd,
  input  logic [AW-1:0]       addr,
  input  lge_pkg::board_dims_t dims,
  output logic                rd_bit,
  output logic                done
);

  localparam int CW = lge_pkg::CELLS_W;
  localparam int RW = lge_pkg::REG_W;

  lge_pkg::sweep_state_t sw_state, sw_state_next;

  // scan position
  logic [RW-1:0]   row, col;
  lge_pkg::phase_t ph;
  logic [CW-1:0]   row_base;
  logic [CW-1:0]   cp;

  // tag of the read in flight
  logic            t_vld, t_edge, t_top_ok, t_bot_ok, t_emit;
  lge_pkg::phase_t t_ph;
  logic [CW-1:0]   t_cell;

  // window: left and middle columns, bit 0 top
  logic       col_top, col_mid;
  logic [2:0] win_left, win_mid, new_col;

  // copy-back pipe
  logic          cw_vld;
  logic [CW-1:0] cw_addr;

  logic          start, issue, last_col, last_row, emit, new_bit;
  logic          scan_copy, flush_copy, copy_rd;
  logic [CW-1:0] ew_c, issue_base, scan_addr;

  logic          cur_we, cur_wdata, cur_rdata, nxt_rdata;
  logic [AW-1:0] cur_waddr, cur_raddr;

  assign ew_c     = CW'(dims.width);
  assign start    = (sw_state == lge_pkg::SW_IDLE) && (cmd.op == lge_pkg::OP_ADVANCE);
  assign issue    = (sw_state == lge_pkg::SW_SCAN);
  assign last_col = (col == dims.width);
  assign last_row = (row == dims.height - RW'(1));

  // read address for the current phase: row above, own row, row below
  always_comb begin
    unique case (ph)
      lge_pkg::PH_TOP: issue_base = row_base - ew_c;
      lge_pkg::PH_BOT: issue_base = row_base + ew_c;
      default:         issue_base = row_base;
    endcase
  end
  assign scan_addr = issue_base + CW'(col);

  // column arriving with the bottom read, edges masked off
  assign new_col = {cur_rdata & t_bot_ok & ~t_edge, col_mid, col_top};
  assign emit    = t_vld && (t_ph == lge_pkg::PH_BOT) && t_emit;
  assign new_bit = lge_pkg::next_cell({new_col, win_mid[2], win_mid[0], win_left},
                                      win_mid[1]);

  // a cell W+1 behind the one just produced is no longer needed in its old form
  assign scan_copy  = emit && (t_cell > ew_c);
  assign flush_copy = (sw_state == lge_pkg::SW_FLUSH) && (cp != dims.cells);
  assign copy_rd    = scan_copy || flush_copy;

  // Sweep state register
  always_ff @(posedge clk) begin
    if (rst) begin
      sw_state <= lge_pkg::SW_IDLE;
      t_vld    <= 1'b0;
      cw_vld   <= 1'b0;
    end else begin
      sw_state <= sw_state_next;
      t_vld    <= issue;
      cw_vld   <= copy_rd;
    end
  end

  // Sweep next state
  always_comb begin
    sw_state_next = sw_state;
    done          = 1'b0;
    unique case (sw_state)
      lge_pkg::SW_IDLE: begin
        if (start) sw_state_next = lge_pkg::SW_SCAN;
      end
      lge_pkg::SW_SCAN: begin
        if ((ph == lge_pkg::PH_BOT) && last_col && last_row) begin
          sw_state_next = lge_pkg::SW_DRAIN;
        end
      end
      lge_pkg::SW_DRAIN: sw_state_next = lge_pkg::SW_FLUSH;
      lge_pkg::SW_FLUSH: begin
        if (cp == dims.cells) begin
          sw_state_next = lge_pkg::SW_IDLE;
          done          = 1'b1;
        end
      end
      default: sw_state_next = lge_pkg::SW_IDLE;
    endcase
  end

  // Scan counters
  always_ff @(posedge clk) begin
    if (start) begin
      row      <= '0;
      col      <= '0;
      ph       <= lge_pkg::PH_TOP;
      row_base <= '0;
    end else if (issue) begin
      unique case (ph)
        lge_pkg::PH_TOP: ph <= lge_pkg::PH_MID;
        lge_pkg::PH_MID: ph <= lge_pkg::PH_BOT;
        lge_pkg::PH_BOT: begin
          ph <= lge_pkg::PH_TOP;
          if (last_col) begin
            col      <= '0;
            row      <= row + RW'(1);
            row_base <= row_base + ew_c;
          end else begin
            col <= col + RW'(1);
          end
        end
        default: ph <= lge_pkg::PH_TOP;
      endcase
    end
  end

  // Copy pointer
  always_ff @(posedge clk) begin
    if (start) begin
      cp <= '0;
    end else if (copy_rd) begin
      cp <= cp + CW'(1);
    end
    cw_addr <= cp;
  end

  // Tag of each issued read
  always_ff @(posedge clk) begin
    if (issue) begin
      t_ph     <= ph;
      t_edge   <= last_col;
      t_top_ok <= (row != '0);
      t_bot_ok <= !last_row;
      t_emit   <= (col != '0);
      t_cell   <= row_base + CW'(col) - CW'(1);
    end
  end

  // Window capture
  always_ff @(posedge clk) begin
    if (t_vld) begin
      unique case (t_ph)
        lge_pkg::PH_TOP: col_top <= cur_rdata & t_top_ok & ~t_edge;
        lge_pkg::PH_MID: col_mid <= cur_rdata & ~t_edge;
        lge_pkg::PH_BOT: begin
          win_left <= t_emit ? win_mid : 3'b000;
          win_mid  <= new_col;
        end
        default: ;
      endcase
    end
  end

  // Current board ports: item access, scan reads, copy-back writes
  assign cur_we    = (cmd.op == lge_pkg::OP_WRITE) || cw_vld;
  assign cur_waddr = cw_vld ? AW'(cw_addr) : addr;
  assign cur_wdata = cw_vld ? nxt_rdata : cmd.value;
  assign cur_raddr = issue ? AW'(scan_addr) : addr;
  assign rd_bit    = cur_rdata;

  lge_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cur_board (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  lge_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_next_board (
    .clk   (clk),
    .we    (emit),
    .waddr (AW'(t_cell)),
    .wdata (new_bit),
    .raddr (AW'(cp)),
    .rdata (nxt_rdata)
  );

  `LGE_ASSERT_NOW(a_copy_no_item_write, cw_vld, cmd.op != lge_pkg::OP_WRITE, "copy-back collides with item write")
  `LGE_ASSERT_NOW(a_cp_bounded, sw_state != lge_pkg::SW_IDLE, cp <= dims.cells, "copy pointer ran past the board")
  `LGE_ASSERT_NOW(a_tag_in_scan, t_vld, (sw_state == lge_pkg::SW_SCAN) || (sw_state == lge_pkg::SW_DRAIN), "window read outside scan")

endmodule

/* verif/tb_life_generation_engine.sv */
// Testbench for the life generation engine: cell writes, reads and B3/S23
// generation steps checked against a board model kept inside the bench.
// Depends on lge_pkg, lge_if and the life_generation_engine RTL.
`timescale 1ns / 1ps

module tb_life_generation_engine;

  localparam int         BOARD_CELLS = lge_pkg::DEFAULT_DEPTH;
  localparam int         FILL_CELLS  = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lge_if #(.payload_t(lge_pkg::item_t))      item_if ();
  lge_if #(.payload_t(lge_pkg::result_t))    result_if ();
  lge_if #(.payload_t(lge_pkg::cfg_write_t)) cfg_if ();

  life_generation_engine dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_if),
    .result_out(result_if),
    .cfg       (cfg_if)
  );

  always #5 clk = ~clk;

  // Board model: live board, scratch for a generation, size registers
  bit                        board_now    [BOARD_CELLS];
  bit                        board_next   [BOARD_CELLS];
  bit                        cell_written [BOARD_CELLS];
  logic [lge_pkg::REG_W-1:0] width_reg;
  logic [lge_pkg::REG_W-1:0] height_reg;

  lge_pkg::result_t expected_outcomes [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  bit sender_holding     = 1'b0;
  int items_sent         = 0;
  int outcomes_checked   = 0;
  int mismatches         = 0;
  int generations        = 0;
  int board_settings     = 0;

  // Register value 0 acts as 1, anything above the maximum saturates
  function automatic int clamp_dim(input logic [lge_pkg::REG_W-1:0] v, input int max_dim);
    if (v == 0) return 1;
    if (v > max_dim) return max_dim;
    return int'(v);
  endfunction

  function automatic int board_area();
    return clamp_dim(width_reg, lge_pkg::DEFAULT_MAX_WIDTH) *
           clamp_dim(height_reg, lge_pkg::DEFAULT_MAX_HEIGHT);
  endfunction

  // True when every cell inside the board already holds a value
  function automatic bit area_written(input int area);
    for (int i = 0; i < area; i++) begin
      if (!cell_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One generation over the W x H window; neighbours outside it count as dead
  function automatic void step_generation();
    int w, h, live, rr, cc;
    w = clamp_dim(width_reg, lge_pkg::DEFAULT_MAX_WIDTH);
    h = clamp_dim(height_reg, lge_pkg::DEFAULT_MAX_HEIGHT);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
              live += board_now[rr * w + cc];
          end
        end
        board_next[r * w + c] = (live == lge_pkg::BIRTH_COUNT) ||
                                (board_now[r * w + c] && live == lge_pkg::SURVIVE_COUNT);
      end
    end
    // cells beyond W*H keep their values
    for (int i = 0; i < w * h; i++) board_now[i] = board_next[i];
  endfunction

  // Apply one item to the board model and return its result
  function automatic lge_pkg::result_t apply_item(input lge_pkg::item_t it);
    lge_pkg::result_t res;
    int               area;
    res  = '0;
    area = board_area();
    case (it.kind)
      lge_pkg::KIND_WRITE: begin
        if (it.cell_index < area) begin
          board_now[it.cell_index]    = it.cell_value;
          cell_written[it.cell_index] = 1'b1;
        end else begin
          res.index_error = 1'b1;
        end
      end
      lge_pkg::KIND_ADVANCE: begin
        step_generation();
      end
      lge_pkg::KIND_READ: begin
        if (it.cell_index < area) res.read_value = board_now[it.cell_index];
        else res.index_error = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Send one item; valid stays high afterwards so a following item can go
  // back to back, and release_sender drops it when nothing follows
  task automatic send_item(input logic [1:0] kind, input int idx, input bit value);
    lge_pkg::item_t it;
    it.kind       = kind;
    it.cell_index = idx[lge_pkg::INDEX_W-1:0];
    it.cell_value = value;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      if (sender_holding) item_if.valid <= 1'b0;
      sender_holding = 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    expected_outcomes.push_back(apply_item(it));
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk); while (!item_if.ready);
    sender_holding = 1'b1;
    items_sent++;
    if (kind == lge_pkg::KIND_ADVANCE) generations++;
  endtask

  task automatic release_sender();
    if (sender_holding) item_if.valid <= 1'b0;
    sender_holding = 1'b0;
  endtask

  task automatic wait_until_drained();
    release_sender();
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // Both size registers, written back to back once the engine is idle
  task automatic set_board(input logic [lge_pkg::REG_W-1:0] w,
                           input logic [lge_pkg::REG_W-1:0] h);
    lge_pkg::cfg_write_t wr;
    wait_until_drained();
    wr.index = lge_pkg::REG_BOARD_WIDTH;
    wr.value = w;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    wr.index = lge_pkg::REG_BOARD_HEIGHT;
    wr.value = h;
    cfg_if.data <= wr;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    width_reg  = w;
    height_reg = h;
    board_settings++;
  endtask

  // Mostly small boards; now and then zero, full size or over-range
  function automatic logic [lge_pkg::REG_W-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return lge_pkg::REG_W'($urandom_range(65, 127));
      2:       return lge_pkg::BOARD_DIM_RESET;
      default: return lge_pkg::REG_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_random_item();
    int         area, pick, idx;
    logic [1:0] kind;
    area = board_area();
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = lge_pkg::KIND_WRITE;
    else if (pick < 75) kind = lge_pkg::KIND_READ;
    else if (pick < 80) kind = KIND_UNUSED;
    else                kind = lge_pkg::KIND_ADVANCE;
    // a generation only over a board whose every cell holds a value
    if (kind == lge_pkg::KIND_ADVANCE && !area_written(area)) kind = lge_pkg::KIND_WRITE;
    pick = $urandom_range(0, 9);
    if (pick < 8)       idx = $urandom_range(0, area - 1);
    else if (pick == 8) idx = area + $urandom_range(0, 2);
    else                idx = $urandom_range(0, BOARD_CELLS - 1);
    // reads inside the board go to cells that hold a value
    if (kind == lge_pkg::KIND_READ && idx < area && !cell_written[idx])
      idx = $urandom_range(0, ((area < FILL_CELLS) ? area : FILL_CELLS) - 1);
    send_item(kind, idx, $urandom_range(0, 1));
  endtask

  // Receiver: ready held low in reset, then stalls at the phase's rate
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    lge_pkg::result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      outcomes_checked++;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected: read_value %0d index_error %0d",
                   $time, result_if.data.read_value, result_if.data.index_error);
      end else begin
        want = expected_outcomes.pop_front();
        if (result_if.data.read_value !== want.read_value)
          report_mismatch("read_value", want.read_value, result_if.data.read_value);
        if (result_if.data.index_error !== want.index_error)
          report_mismatch("index_error", want.index_error, result_if.data.index_error);
      end
    end
  end

  // The first 64 cells get a value, enough for every board of up to 64
  // cells; runs at the reset size of 64 x 64
  task automatic test_fill_board();
    for (int i = 0; i < FILL_CELLS; i++)
      send_item(lge_pkg::KIND_WRITE, i, $urandom_range(0, 2) == 0);
  endtask

  task automatic test_directed_cases();
    // full board: both ends of the index range, unused kind, read back
    send_item(lge_pkg::KIND_READ, 0, 1'b0);
    send_item(lge_pkg::KIND_WRITE, BOARD_CELLS - 1, 1'b1);
    send_item(KIND_UNUSED, BOARD_CELLS - 1, 1'b0);
    send_item(lge_pkg::KIND_READ, BOARD_CELLS - 1, 1'b1);
    // zero width acts as one, over-range height saturates: one column
    set_board(0, 127);
    send_item(lge_pkg::KIND_WRITE, 63, 1'b1);
    send_item(lge_pkg::KIND_WRITE, 64, 1'b1);
    send_item(lge_pkg::KIND_READ, 64, 1'b0);
    send_item(lge_pkg::KIND_ADVANCE, 0, 1'b0);
    send_item(lge_pkg::KIND_READ, 63, 1'b0);
    // the mirror case: one row of 64
    set_board(127, 0);
    send_item(lge_pkg::KIND_ADVANCE, BOARD_CELLS - 1, 1'b1);
    send_item(lge_pkg::KIND_READ, 0, 1'b0);
    send_item(lge_pkg::KIND_READ, 64, 1'b0);
    // 2 x 2 block is a still life
    set_board(2, 2);
    for (int i = 0; i < 4; i++) send_item(lge_pkg::KIND_WRITE, i, 1'b1);
    send_item(lge_pkg::KIND_ADVANCE, 0, 1'b0);
    send_item(lge_pkg::KIND_READ, 3, 1'b0);
    send_item(lge_pkg::KIND_READ, 4, 1'b0);
    // back to full size: the last cell kept its value
    set_board(64, 64);
    send_item(lge_pkg::KIND_READ, BOARD_CELLS - 1, 1'b0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    int remaining;
    remaining = count;
    wait_until_drained();
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (remaining > 0) begin
      set_board(random_dim(), random_dim());
      for (int k = 0; k < 12 && remaining > 0; k++) begin
        send_random_item();
        remaining--;
      end
    end
  endtask

  initial begin
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    width_reg       = lge_pkg::BOARD_DIM_RESET;
    height_reg      = lge_pkg::BOARD_DIM_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_fill_board();
    test_directed_cases();
    test_random_phase(0, 0, 14);
    test_random_phase(73, 0, 14);
    test_random_phase(0, 73, 14);
    test_random_phase(13, 13, 14);

    wait_until_drained();
    repeat (100) @(posedge clk);
    $display("Run covered %0d items, %0d generation steps and %0d board sizes.",
             items_sent, generations, board_settings);
    $display("%0d results checked, %0d mismatches.", outcomes_checked, mismatches);
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule
